// File: src/qlg_pkg.sv
package qlg_pkg;

	localparam int NUM_LEGS    = 4;
	localparam int LEG_W       = 2;
	localparam int PULSE_W     = 12;
	localparam int POS_W       = 14;
	localparam int TRIM_W      = 9;
	localparam int FRAME_W     = 10;
	localparam int START_W     = 8;
	localparam int AMP_W       = 7;
	localparam int OFF_W       = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 16;

	localparam logic [LEG_W-1:0] LEG_LAST = 2'd3;

	// Input command codes.
	typedef enum logic [2:0] {
		CMD_TICK  = 3'd0,
		CMD_WALK  = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_STEER = 3'd3,
		CMD_LOWER = 3'd4,
		CMD_RAISE = 3'd5
	} qlg_cmd_code_t;

	// Steering directions; anything above TURN_RIGHT is ignored.
	localparam logic [1:0] TURN_NONE  = 2'd0;
	localparam logic [1:0] TURN_LEFT  = 2'd1;
	localparam logic [1:0] TURN_RIGHT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_MIN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVO_MAX    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CYCLE_FRAMES = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_AMP_PERCENT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIM_RF      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIM_RB      = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIM_LF      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIM_LB      = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [PULSE_W-1:0]        SERVO_MIN_RST    = 12'd150;
	localparam logic [PULSE_W-1:0]        SERVO_MAX_RST    = 12'd600;
	localparam logic [FRAME_W-1:0]        CYCLE_FRAMES_RST = 10'd200;
	localparam logic [AMP_W-1:0]          AMP_PERCENT_RST  = 7'd100;
	localparam logic signed [TRIM_W-1:0] TRIM_RF_RST      = 9'sd80;
	localparam logic signed [TRIM_W-1:0] TRIM_RB_RST      = -9'sd10;
	localparam logic signed [TRIM_W-1:0] TRIM_LF_RST      = 9'sd25;
	localparam logic signed [TRIM_W-1:0] TRIM_LB_RST      = 9'sd35;

	localparam int POS_RST_INT = (150 + 600) / 2;
	localparam logic signed [POS_W-1:0] POS_RST = 14'(POS_RST_INT);
	localparam logic signed [POS_W-1:0] POS_MAX = 14'sd8191;
	localparam logic signed [POS_W-1:0] POS_MIN = -14'sd8192;

	// Bit set means the leg's heading is negative (right legs by default).
	localparam logic [NUM_LEGS-1:0] HEADING_NEG_RST = 4'b0011;

	typedef logic [START_W-1:0] start_set_t [NUM_LEGS];

	// Start frames of each leg for the three steering modes.
	function automatic start_set_t steer_starts(input logic [1:0] dir);
		start_set_t s;
		unique case (dir)
			TURN_LEFT:  s = '{8'd0, 8'd100, 8'd50, 8'd150};
			TURN_RIGHT: s = '{8'd50, 8'd150, 8'd0, 8'd100};
			default:    s = '{8'd0, 8'd100, 8'd100, 8'd0};
		endcase
		return s;
	endfunction

	// What one result step of the datapath does.
	typedef enum logic [1:0] {
		OP_TICK,
		OP_ZERO,
		OP_GAIT,
		OP_SWEEP
	} qlg_op_t;

	typedef struct packed {
		logic             set_moving;
		logic             clr_moving;
		logic             default_heading;
		logic             apply_steer;
		logic [1:0]       steer_dir;
		logic             step;
		qlg_op_t          op;
		logic [LEG_W-1:0] leg;
		logic [OFF_W-1:0] off;
		logic             last;
		logic             frame_advance;
	} qlg_ctl_t;

	typedef struct packed {
		logic       moving;
		logic [1:0] steer_mode;
		logic       out_free;
	} qlg_stat_t;

endpackage

// File: src/qlg_ctrl.sv
module qlg_ctrl import qlg_pkg::*; #(
	parameter int LOWER_STEPS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] in_cmd,
	input  logic [1:0] in_dir,
	input  qlg_stat_t  stat,
	output qlg_ctl_t   ctl
);

	localparam int RW = (LOWER_STEPS > 1) ? $clog2(LOWER_STEPS) : 1;
	localparam logic [RW-1:0] ROUND_LAST = RW'(LOWER_STEPS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [2:0]       cmd_q;
	logic [1:0]       dir_q;
	qlg_op_t          op_q;
	logic             raise_q;
	logic [LEG_W-1:0] leg_q;
	logic [RW-1:0]    round_q;

	logic steer_ok;
	logic is_decode;
	logic step;
	logic last;

	assign in_ready  = (state_q == ST_IDLE);
	assign is_decode = (state_q == ST_DECODE);
	assign steer_ok  = (dir_q <= TURN_RIGHT) && (dir_q != stat.steer_mode);
	assign step      = (state_q == ST_EMIT) && stat.out_free;
	assign last      = (leg_q == LEG_LAST) && ((op_q != OP_SWEEP) || (round_q == ROUND_LAST));

	always_comb begin
		ctl.set_moving      = is_decode && (cmd_q == CMD_WALK);
		ctl.clr_moving      = is_decode && ((cmd_q == CMD_STOP) || (cmd_q == CMD_LOWER) ||
		                                    (cmd_q == CMD_RAISE));
		ctl.apply_steer     = is_decode && (cmd_q == CMD_STEER) && steer_ok;
		ctl.default_heading = ctl.apply_steer ||
		                      (is_decode && ((cmd_q == CMD_LOWER) || (cmd_q == CMD_RAISE)));
		ctl.steer_dir       = dir_q;
		ctl.step            = step;
		ctl.op              = op_q;
		ctl.leg             = leg_q;
		ctl.off             = raise_q ? (OFF_W'(LOWER_STEPS) - OFF_W'(round_q)) : OFF_W'(round_q);
		ctl.last            = last;
		ctl.frame_advance   = step && (op_q == OP_TICK) && (leg_q == LEG_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_TICK;
			dir_q   <= TURN_NONE;
			op_q    <= OP_TICK;
			raise_q <= 1'b0;
			leg_q   <= '0;
			round_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						dir_q   <= in_dir;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					leg_q   <= '0;
					round_q <= '0;
					state_q <= ST_IDLE;
					unique case (cmd_q)
						CMD_TICK: begin
							if (stat.moving) begin
								op_q    <= OP_TICK;
								state_q <= ST_EMIT;
							end
						end
						CMD_STOP: begin
							op_q    <= OP_ZERO;
							state_q <= ST_EMIT;
						end
						CMD_STEER: begin
							if (steer_ok) begin
								op_q    <= OP_GAIT;
								state_q <= ST_EMIT;
							end
						end
						CMD_LOWER: begin
							op_q    <= OP_SWEEP;
							raise_q <= 1'b0;
							state_q <= ST_EMIT;
						end
						CMD_RAISE: begin
							op_q    <= OP_SWEEP;
							raise_q <= 1'b1;
							state_q <= ST_EMIT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_EMIT: begin
					if (step) begin
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							leg_q <= leg_q + 2'd1;
							if (leg_q == LEG_LAST) begin
								round_q <= round_q + RW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/qlg_datapath.sv
module qlg_datapath import qlg_pkg::*; #(
	parameter int STEP_SIZE = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  qlg_ctl_t               ctl,
	output qlg_stat_t              stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_DATA_W-1:0]  out_data,
	output logic                   out_last
);

	localparam logic signed [POS_W:0] STEP_P = (POS_W+1)'(STEP_SIZE);
	localparam logic signed [23:0]    STEP_N = 24'(STEP_SIZE);

	// Configuration registers.
	logic [PULSE_W-1:0]        servo_min_q;
	logic [PULSE_W-1:0]        servo_max_q;
	logic [FRAME_W-1:0]        cycle_frames_q;
	logic [AMP_W-1:0]          amp_q;
	logic signed [TRIM_W-1:0] trim_q [NUM_LEGS];

	// Products of configuration values, refreshed every cycle.
	logic signed [20:0] amp_range_q;
	logic signed [20:0] max_amp_q;
	logic signed [20:0] min_amp_q;

	// Gait state.
	logic signed [POS_W-1:0] pos_q [NUM_LEGS];
	logic [NUM_LEGS-1:0]     neg_q;
	logic [NUM_LEGS-1:0]     started_q;
	start_set_t              start_q;
	logic [FRAME_W-1:0]      frame_q;
	logic [1:0]              steer_q;
	logic                    moving_q;

	// Output register.
	logic                 out_valid_q;
	logic [LEG_W-1:0]     out_leg_q;
	logic [PULSE_W-1:0]   out_pulse_q;
	logic                 out_walking_q;
	logic                 out_last_q;

	logic signed [12:0]      range;
	logic [PULSE_W:0]        mid_sum;
	logic [PULSE_W-1:0]      mid;
	logic signed [POS_W-1:0] pos_cur;
	logic signed [POS_W:0]   moved_sum;
	logic signed [POS_W-1:0] moved;
	logic signed [20:0]      p100;
	logic                    flip;
	logic signed [11:0]      start_diff;
	logic signed [23:0]      overlap_num;
	logic signed [23:0]      overlap_thr;
	logic                    do_move;
	logic signed [POS_W-1:0] sweep_pos;
	logic [PULSE_W-1:0]      pulse;
	logic [FRAME_W:0]        frame_next;

	function automatic logic [PULSE_W-1:0] trim_pulse(input logic signed [POS_W-1:0] p,
	                                                  input logic signed [TRIM_W-1:0] t);
		logic signed [POS_W:0] v;
		v = (POS_W+1)'(p) + (POS_W+1)'(t);
		if (v < 0) begin
			return '0;
		end else if (v > 15'sd4095) begin
			return '1;
		end else begin
			return v[PULSE_W-1:0];
		end
	endfunction

	assign range   = $signed({1'b0, servo_max_q}) - $signed({1'b0, servo_min_q});
	assign mid_sum = {1'b0, servo_min_q} + {1'b0, servo_max_q};
	assign mid     = mid_sum[PULSE_W:1];

	// Step of a moving leg, saturated to the position range.
	assign pos_cur   = pos_q[ctl.leg];
	assign moved_sum = (POS_W+1)'(pos_cur) + (neg_q[ctl.leg] ? -STEP_P : STEP_P);
	always_comb begin
		if (moved_sum > (POS_W+1)'(POS_MAX)) begin
			moved = POS_MAX;
		end else if (moved_sum < (POS_W+1)'(POS_MIN)) begin
			moved = POS_MIN;
		end else begin
			moved = moved_sum[POS_W-1:0];
		end
	end

	// Reversal test against the amplitude-scaled bounds, scaled by 100.
	assign p100 = 21'(moved) * 21'sd100;
	assign flip = (p100 > max_amp_q) || (p100 < min_amp_q);

	// The overlap window is open while (frame + 1) * step stays within the
	// numerator of the window length; a negative numerator never opens it.
	assign start_diff  = $signed({4'b0, start_q[ctl.leg]}) - $signed({2'b0, cycle_frames_q});
	assign overlap_num = 24'(start_diff) * STEP_N + 24'(amp_range_q);
	assign overlap_thr = $signed({13'b0, frame_next}) * STEP_N;
	assign frame_next  = (FRAME_W+1)'(frame_q) + (FRAME_W+1)'(1);
	assign do_move     = ({2'b0, start_q[ctl.leg]} <= frame_q) ||
	                     (started_q[ctl.leg] && (overlap_num >= overlap_thr));

	assign sweep_pos = $signed({2'b0, mid}) +
	                   (neg_q[ctl.leg] ? -$signed({9'b0, ctl.off}) : $signed({9'b0, ctl.off}));

	always_comb begin
		unique case (ctl.op)
			OP_TICK:  pulse = trim_pulse(pos_cur, trim_q[ctl.leg]);
			OP_GAIT:  pulse = trim_pulse($signed({2'b0, mid}), trim_q[ctl.leg]);
			OP_SWEEP: pulse = trim_pulse(sweep_pos, trim_q[ctl.leg]);
			default:  pulse = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_min_q    <= SERVO_MIN_RST;
			servo_max_q    <= SERVO_MAX_RST;
			cycle_frames_q <= CYCLE_FRAMES_RST;
			amp_q          <= AMP_PERCENT_RST;
			trim_q         <= '{TRIM_RF_RST, TRIM_RB_RST, TRIM_LF_RST, TRIM_LB_RST};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SERVO_MIN:    servo_min_q    <= cfg_data;
				REG_SERVO_MAX:    servo_max_q    <= cfg_data;
				REG_CYCLE_FRAMES: cycle_frames_q <= cfg_data[FRAME_W-1:0];
				REG_AMP_PERCENT:  amp_q          <= cfg_data[AMP_W-1:0];
				REG_TRIM_RF:      trim_q[0]      <= $signed(cfg_data[TRIM_W-1:0]);
				REG_TRIM_RB:      trim_q[1]      <= $signed(cfg_data[TRIM_W-1:0]);
				REG_TRIM_LF:      trim_q[2]      <= $signed(cfg_data[TRIM_W-1:0]);
				REG_TRIM_LB:      trim_q[3]      <= $signed(cfg_data[TRIM_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		amp_range_q <= 21'(range) * $signed({14'b0, amp_q});
		max_amp_q   <= $signed(21'(servo_max_q) * 21'(amp_q));
		min_amp_q   <= $signed(21'(servo_min_q) * 21'(amp_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '{POS_RST, POS_RST, POS_RST, POS_RST};
			neg_q     <= HEADING_NEG_RST;
			started_q <= '0;
			start_q   <= steer_starts(TURN_NONE);
			frame_q   <= '0;
			steer_q   <= TURN_NONE;
			moving_q  <= 1'b0;
		end else begin
			if (ctl.set_moving) begin
				moving_q <= 1'b1;
			end else if (ctl.clr_moving) begin
				moving_q <= 1'b0;
			end
			if (ctl.apply_steer) begin
				steer_q <= ctl.steer_dir;
				start_q <= steer_starts(ctl.steer_dir);
				frame_q <= '0;
			end
			if (ctl.default_heading) begin
				neg_q <= HEADING_NEG_RST;
			end
			if (ctl.step) begin
				unique case (ctl.op)
					OP_TICK: begin
						if (do_move) begin
							started_q[ctl.leg] <= 1'b1;
							pos_q[ctl.leg]     <= moved;
							if (flip) begin
								neg_q[ctl.leg] <= ~neg_q[ctl.leg];
							end
						end
					end
					OP_GAIT: begin
						pos_q[ctl.leg]     <= $signed({2'b0, mid});
						started_q[ctl.leg] <= 1'b0;
					end
					OP_SWEEP: begin
						pos_q[ctl.leg]     <= sweep_pos;
						started_q[ctl.leg] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.frame_advance) begin
				frame_q <= (frame_next > {1'b0, cycle_frames_q}) ? '0 : frame_next[FRAME_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			out_leg_q     <= ctl.leg;
			out_pulse_q   <= pulse;
			out_walking_q <= moving_q;
			out_last_q    <= ctl.last;
		end
	end

	assign stat.moving     = moving_q;
	assign stat.steer_mode = steer_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, out_walking_q, out_pulse_q, out_leg_q};
	assign out_last  = out_last_q;

endmodule

// File: src/quad_leg_gait_sequencer.sv
// Four-leg gait sequencer. An accepted command is decoded in the cycle after
// its transfer; its N results (0, 4, or 4 * LOWER_STEPS) then leave one per cycle,
// unless the output stalls, through a registered output stage. A new command is
// accepted only once the result stepper, one leg per cycle, has issued the last
// result of the previous one. arst_n at once resets control, configuration and
// gait state to the defaults: straight steering, legs mid-range, gait stopped.
module quad_leg_gait_sequencer import qlg_pkg::*; #(
	parameter int STEP_SIZE   = 1,
	parameter int LOWER_STEPS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// Command stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // [2:0] cmd, [4:3] steer_dir, [7:5] zero

	// Pulse result stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [1:0] leg_index, [13:2] pulse,
	                                               // [14] walking, [15] zero
	output logic                   m_axis_tlast,   // final result of the command

	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	qlg_ctl_t  ctl;
	qlg_stat_t stat;

	// Register writes are taken as soon as they are presented, so the channel never stalls.
	// Writes are expected only while no command is in progress.
	assign cfg_ready = 1'b1;

	// The controller sequences each command: it decodes the transfer, then
	// walks the legs (and the sweep rounds for lower and raise), issuing one
	// result step per cycle whenever the output register can take a result.
	qlg_ctrl #(
		.LOWER_STEPS(LOWER_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tdata[2:0]),
		.in_dir   (s_axis_tdata[4:3]),
		.stat     (stat),
		.ctl      (ctl)
	);

	// The datapath holds the configuration, the leg state and the output
	// register. Each step emits a pulse for the addressed leg and may update
	// that leg: a frame tick reports the trimmed position before the move, a gait
	// reset or sweep reports the newly set trimmed position; a stop reports zero.
	qlg_datapath #(
		.STEP_SIZE(STEP_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// File: bench/quad_leg_gait_sequencer_tb.sv
module quad_leg_gait_sequencer_tb import qlg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// Build parameters of the block under test; the predictor uses the same values.
	localparam int STEP_SIZE   = 1;
	localparam int LOWER_STEPS = 16;

	// Codes that the block must ignore. They have no names in the package.
	localparam logic [2:0] CMD_BAD_LOW  = 3'd6;
	localparam logic [2:0] CMD_BAD_HIGH = 3'd7;
	localparam logic [1:0] STEER_BAD    = 2'd3;

	// Cycles to let pass once the last expected pulse has arrived, so that a
	// command that emits nothing (walk, idle tick) has surely been absorbed.
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_GAP       = 13;

	// One expected pulse transfer on the result stream.
	typedef struct {
		logic [LEG_W-1:0]   leg;
		logic [PULSE_W-1:0] pulse;
		logic               walking;
		logic               last;
	} gait_pulse_t;

	// Gait predictor and pulse scoreboard. It keeps its own copy of the
	// registers and of the leg state, turns every accepted command into the
	// pulses it must cause and compares the result stream against them.
	class gait_pulse_board;
		logic [PULSE_W-1:0]       servo_min;
		logic [PULSE_W-1:0]       servo_max;
		logic [FRAME_W-1:0]       cycle_last;
		logic [AMP_W-1:0]         amp;
		logic signed [TRIM_W-1:0] trim [NUM_LEGS];

		logic signed [POS_W-1:0]  pos [NUM_LEGS];
		logic                     heading_neg [NUM_LEGS];
		logic                     started [NUM_LEGS];
		logic [START_W-1:0]       start_at [NUM_LEGS];
		logic [FRAME_W-1:0]       frame;
		logic [1:0]               steer;
		logic                     moving;
		int                       start_sets [3][NUM_LEGS];

		gait_pulse_t pending_pulses [$];
		int          errors;

		function new();
			start_sets = '{'{0, 100, 100, 0}, '{0, 100, 50, 150}, '{50, 150, 0, 100}};
			servo_min  = SERVO_MIN_RST;
			servo_max  = SERVO_MAX_RST;
			cycle_last = CYCLE_FRAMES_RST;
			amp        = AMP_PERCENT_RST;
			trim[0]    = TRIM_RF_RST;
			trim[1]    = TRIM_RB_RST;
			trim[2]    = TRIM_LF_RST;
			trim[3]    = TRIM_LB_RST;
			for (int s = 0; s < NUM_LEGS; s++) begin
				pos[s]      = POS_W'(middle());
				started[s]  = 1'b0;
				start_at[s] = START_W'(start_sets[0][s]);
			end
			set_default_headings();
			frame   = '0;
			steer   = TURN_NONE;
			moving  = 1'b0;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SERVO_MIN:    servo_min  = data[PULSE_W-1:0];
				REG_SERVO_MAX:    servo_max  = data[PULSE_W-1:0];
				REG_CYCLE_FRAMES: cycle_last = data[FRAME_W-1:0];
				REG_AMP_PERCENT:  amp        = data[AMP_W-1:0];
				REG_TRIM_RF:      trim[0]    = data[TRIM_W-1:0];
				REG_TRIM_RB:      trim[1]    = data[TRIM_W-1:0];
				REG_TRIM_LF:      trim[2]    = data[TRIM_W-1:0];
				REG_TRIM_LB:      trim[3]    = data[TRIM_W-1:0];
				default: ;
			endcase
		endfunction

		function longint middle();
			return (longint'(servo_min) + longint'(servo_max)) / 2;
		endfunction

		// Positions live in a 14-bit signed register that clips instead of wrapping.
		function logic signed [POS_W-1:0] clip_pos(longint p);
			if (p > 8191)
				return 14'sd8191;
			if (p < -8192)
				return -14'sd8192;
			return POS_W'(p);
		endfunction

		function logic [PULSE_W-1:0] trimmed(int leg);
			longint v;
			v = longint'(pos[leg]) + longint'(trim[leg]);
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return PULSE_W'(v);
		endfunction

		function void set_default_headings();
			for (int s = 0; s < NUM_LEGS; s++)
				heading_neg[s] = (s < 2);
		endfunction

		function void expect_pulse(int leg, logic [PULSE_W-1:0] pulse, logic last);
			gait_pulse_t p;
			p.leg     = LEG_W'(leg);
			p.pulse   = pulse;
			p.walking = moving;
			p.last    = last;
			pending_pulses.push_back(p);
		endfunction

		// One frame: every leg reports its pulse first and then may take a step.
		function void advance_frame();
			longint span, ovl, p100;
			int     nxt;
			if (!moving)
				return;
			span = longint'(servo_max) - longint'(servo_min);
			for (int s = 0; s < NUM_LEGS; s++) begin
				expect_pulse(s, trimmed(s), s == NUM_LEGS - 1);
				ovl = ((longint'(start_at[s]) - longint'(cycle_last)) * STEP_SIZE
				       + longint'(amp) * span) / STEP_SIZE;
				if (longint'(frame) >= longint'(start_at[s]) ||
				    (longint'(frame) < ovl && started[s])) begin
					started[s] = 1'b1;
					pos[s] = clip_pos(longint'(pos[s]) + (heading_neg[s] ? -STEP_SIZE : STEP_SIZE));
					p100 = longint'(pos[s]) * 100;
					if (p100 > longint'(servo_max) * longint'(amp) ||
					    p100 < longint'(servo_min) * longint'(amp))
						heading_neg[s] = !heading_neg[s];
				end
			end
			nxt = int'(frame) + 1;
			if (nxt > int'(cycle_last))
				nxt = 0;
			frame = FRAME_W'(nxt);
		endfunction

		function void restart_gait();
			for (int s = 0; s < NUM_LEGS; s++) begin
				pos[s]     = clip_pos(middle());
				started[s] = 1'b0;
				expect_pulse(s, trimmed(s), s == NUM_LEGS - 1);
			end
			set_default_headings();
			frame = '0;
		endfunction

		// Lowering walks each leg out from the middle, raising walks it back in.
		function void sweep_legs(logic raise);
			longint off;
			set_default_headings();
			moving = 1'b0;
			for (int d = 0; d < LOWER_STEPS; d++) begin
				off = raise ? LOWER_STEPS - d : d;
				for (int s = 0; s < NUM_LEGS; s++) begin
					pos[s]     = clip_pos(middle() + (heading_neg[s] ? -off : off));
					started[s] = 1'b0;
					expect_pulse(s, trimmed(s), d == LOWER_STEPS - 1 && s == NUM_LEGS - 1);
				end
			end
		endfunction

		function void take_command(logic [2:0] cmd, logic [1:0] dir);
			case (cmd)
				CMD_TICK:  advance_frame();
				CMD_WALK:  moving = 1'b1;
				CMD_STOP: begin
					moving = 1'b0;
					for (int s = 0; s < NUM_LEGS; s++)
						expect_pulse(s, '0, s == NUM_LEGS - 1);
				end
				CMD_STEER: begin
					if (dir != STEER_BAD && dir != steer) begin
						steer = dir;
						for (int s = 0; s < NUM_LEGS; s++)
							start_at[s] = START_W'(start_sets[dir][s]);
						restart_gait();
					end
				end
				CMD_LOWER: sweep_legs(1'b0);
				CMD_RAISE: sweep_legs(1'b1);
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_pulse(logic [LEG_W-1:0] leg, logic [PULSE_W-1:0] pulse, logic walking,
		                 logic last);
			gait_pulse_t want;
			if (pending_pulses.size() == 0) begin
				report_mismatch($sformatf("unexpected pulse leg %0d value %0d", leg, pulse));
				return;
			end
			want = pending_pulses.pop_front();
			if (leg !== want.leg)
				report_mismatch($sformatf("leg index %0d, expected %0d", leg, want.leg));
			if (pulse !== want.pulse)
				report_mismatch($sformatf("leg %0d pulse %0d, expected %0d",
				                          want.leg, pulse, want.pulse));
			if (walking !== want.walking)
				report_mismatch($sformatf("leg %0d walking %b, expected %b",
				                          want.leg, walking, want.walking));
			if (last !== want.last)
				report_mismatch($sformatf("leg %0d last %b, expected %b",
				                          want.leg, last, want.last));
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [2:0] cmd, [4:3] steer_dir, [7:5] zero
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [1:0] leg_index, [13:2] pulse,
	                                             // [14] walking, [15] zero
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	gait_pulse_board board = new();

	// Idle bursts: while a flag is set, that side runs without any gaps.
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int rx_wait  = 0;

	quad_leg_gait_sequencer #(
		.STEP_SIZE  (STEP_SIZE),
		.LOWER_STEPS(LOWER_STEPS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Result side. Outputs are sampled at the rising edge, before the block's
	// own updates of that edge land, so each transfer is seen exactly once.
	// After every transfer the receiver draws a fresh stall length; the ready
	// line is written once per edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_pulse(m_axis_tdata[1:0], m_axis_tdata[13:2], m_axis_tdata[14],
				                  m_axis_tlast);
				if ($urandom_range(0, 59) == 0)
					rx_burst = !rx_burst;
				rx_wait = pick_gap(rx_burst);
			end
			if (rx_wait > 0) begin
				m_axis_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Sends one command. The valid line stays high straight into the next
	// command when no gap is drawn; here it is only dropped when a gap follows.
	task automatic send_cmd(input logic [2:0] cmd, input logic [1:0] dir);
		int gap;
		if ($urandom_range(0, 24) == 0)
			tx_burst = !tx_burst;
		gap = pick_gap(tx_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, dir, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.take_command(cmd, dir);
	endtask

	// Holds the command stream off until every expected pulse is back and the
	// block has had time to absorb commands that emit nothing.
	task automatic drain_pulses();
		s_axis_tvalid <= 1'b0;
		while (board.pending_pulses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// Writes all eight registers back to back; only called with the block idle.
	task automatic apply_setting(input logic [PULSE_W-1:0] smin, input logic [PULSE_W-1:0] smax,
	                             input logic [FRAME_W-1:0] cyc, input logic [AMP_W-1:0] amp,
	                             input logic [TRIM_W-1:0] t_rf, input logic [TRIM_W-1:0] t_rb,
	                             input logic [TRIM_W-1:0] t_lf, input logic [TRIM_W-1:0] t_lb);
		write_reg(REG_SERVO_MIN, CFG_DATA_W'(smin));
		write_reg(REG_SERVO_MAX, CFG_DATA_W'(smax));
		write_reg(REG_CYCLE_FRAMES, CFG_DATA_W'(cyc));
		write_reg(REG_AMP_PERCENT, CFG_DATA_W'(amp));
		write_reg(REG_TRIM_RF, CFG_DATA_W'(t_rf));
		write_reg(REG_TRIM_RB, CFG_DATA_W'(t_rb));
		write_reg(REG_TRIM_LF, CFG_DATA_W'(t_lf));
		write_reg(REG_TRIM_LB, CFG_DATA_W'(t_lb));
		cfg_valid <= 1'b0;
	endtask

	// Random command stream. Mostly frame ticks while walking, since the leg
	// logic only gets deep with long runs of ticks; a stopped gait is usually
	// restarted quickly. steer_pct sets how often the gait is reset by steering.
	// Unused codes and steering to the invalid direction are sent as noise but do not count toward n_cmds.
	task automatic run_random(input int n_cmds, input int steer_pct);
		int         done;
		int         r;
		logic [2:0] cmd;
		logic [1:0] dir;
		done = 0;
		while (done < n_cmds) begin
			r   = $urandom_range(0, 99);
			dir = 2'($urandom_range(0, 3));
			if (r < 70)
				cmd = (!board.moving && $urandom_range(0, 1)) ? CMD_WALK : CMD_TICK;
			else if (r < 75)
				cmd = CMD_WALK;
			else if (r < 79)
				cmd = CMD_STOP;
			else if (r < 79 + steer_pct)
				cmd = CMD_STEER;
			else if (r < 93)
				cmd = $urandom_range(0, 1) ? CMD_LOWER : CMD_RAISE;
			else if (r < 97)
				cmd = $urandom_range(0, 1) ? CMD_BAD_LOW : CMD_BAD_HIGH;
			else
				cmd = CMD_TICK;
			send_cmd(cmd, dir);
			if (!(cmd == CMD_BAD_LOW || cmd == CMD_BAD_HIGH ||
			      (cmd == CMD_STEER && dir == STEER_BAD)))
				done++;
			// Now and then the sender waits for the result stream to run dry.
			if ($urandom_range(0, 39) == 0)
				drain_pulses();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset register values: a tick while stopped,
		// walking, steering to the current mode and to an invalid direction,
		// every steering mode, stop, both sweeps and the two unused codes.
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_WALK, TURN_NONE);
		send_cmd(CMD_TICK, TURN_LEFT);
		send_cmd(CMD_TICK, TURN_RIGHT);
		send_cmd(CMD_TICK, STEER_BAD);
		send_cmd(CMD_STEER, TURN_NONE);
		send_cmd(CMD_STEER, TURN_LEFT);
		send_cmd(CMD_STEER, TURN_LEFT);
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_STEER, TURN_RIGHT);
		send_cmd(CMD_STEER, STEER_BAD);
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_STOP, STEER_BAD);
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_LOWER, TURN_LEFT);
		send_cmd(CMD_RAISE, TURN_RIGHT);
		send_cmd(CMD_BAD_LOW, TURN_NONE);
		send_cmd(CMD_BAD_HIGH, STEER_BAD);
		send_cmd(CMD_WALK, TURN_RIGHT);
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_TICK, TURN_NONE);
		send_cmd(CMD_STEER, TURN_NONE);
		send_cmd(CMD_TICK, TURN_LEFT);
		send_cmd(CMD_STOP, TURN_NONE);
		drain_pulses();

		// Full servo span, longest frame cycle, trims at both ends.
		apply_setting(12'd0, 12'd4095, 10'd1023, 7'd100, 9'h0FF, 9'h100, 9'h000, 9'h1FF);
		run_random(25, 8);
		drain_pulses();

		// Narrow span and small amplitude, so that the overlap window closes
		// inside a short frame cycle and started legs stop between starts.
		apply_setting(12'd300, 12'd302, 10'd60, 7'd10, 9'h010, 9'h1F0, 9'h000, 9'h020);
		run_random(45, 10);
		drain_pulses();

		// Minimum is above maximum, amplitude and cycle at their lowest; the
		// trims push pulses past the top of the range.
		apply_setting(12'd4095, 12'd3900, 10'd1, 7'd1, 9'h0FF, 9'h100, 9'h0FF, 9'h100);
		run_random(20, 8);
		drain_pulses();

		// Default servo range with a cycle long enough for late legs to start;
		// little steering so the frame counter gets far.
		apply_setting(12'd150, 12'd600, 10'd120, 7'd100, 9'h050, 9'h1F6, 9'h019, 9'h023);
		run_random(40, 1);
		drain_pulses();

		apply_setting(PULSE_W'($urandom_range(0, 4095)), PULSE_W'($urandom_range(0, 4095)),
		              FRAME_W'($urandom_range(1, 1023)), AMP_W'($urandom_range(1, 100)),
		              TRIM_W'($urandom_range(0, 511)), TRIM_W'($urandom_range(0, 511)),
		              TRIM_W'($urandom_range(0, 511)), TRIM_W'($urandom_range(0, 511)));
		run_random(35, 8);
		drain_pulses();

		// Tiny range near zero: negative trims clip pulses at zero.
		apply_setting(12'd0, 12'd60, 10'd1023, 7'd100, 9'h100, 9'h100, 9'h0FF, 9'h000);
		run_random(25, 8);
		drain_pulses();

		repeat (20) @(posedge clk);
		if (board.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#15_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
